// ===== sv/iir_df1_pkg.sv =====
package iir_df1_pkg;

  localparam int unsigned TAPS_DEFAULT      = 5;
  localparam int unsigned SAMPLE_W_DEFAULT  = 16;
  localparam int unsigned COEF_FRAC_DEFAULT = 20;

  localparam int unsigned COEF_W     = 24;
  localparam int unsigned HIST_EXTRA = 8;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 2 * COEF_W;

  // b0..b4 then a1..a4
  localparam int unsigned NUM_COEFS     = 9;
  localparam int unsigned COEF_IDX_W    = 4;
  localparam int unsigned LAST_COEF_TAP = 4;
  localparam int unsigned TAP_W         = 3;

  localparam int unsigned STEP_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0_B1,
    REG_B2_B3,
    REG_B4_A1,
    REG_A2_A3,
    REG_A4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_MAC_B,
    OP_MAC_A,
    OP_DRAIN,
    OP_ROUND_H,
    OP_ROUND_Y,
    OP_WRITE
  } uop_e;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_OUT
  } hold_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    uop_e             op;
    logic [TAP_W-1:0] tap;
    hold_e            hold;
    step_t            next;
  } ucode_t;

  localparam step_t STEP_IDLE = '0;

  function automatic ucode_t uc(uop_e op, int unsigned tap, hold_e hold, int unsigned next);
    ucode_t w;
    w.op   = op;
    w.tap  = TAP_W'(tap);
    w.hold = hold;
    w.next = STEP_W'(next);
    return w;
  endfunction

  // Microprogram: wait for a sample, nine MACs, drain, two roundings, write-back.
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    unique case (s)
      4'd0:    w = uc(OP_IDLE,    0, HOLD_IN,   1);
      4'd1:    w = uc(OP_MAC_B,   0, HOLD_NONE, 2);
      4'd2:    w = uc(OP_MAC_B,   1, HOLD_NONE, 3);
      4'd3:    w = uc(OP_MAC_B,   2, HOLD_NONE, 4);
      4'd4:    w = uc(OP_MAC_B,   3, HOLD_NONE, 5);
      4'd5:    w = uc(OP_MAC_B,   4, HOLD_NONE, 6);
      4'd6:    w = uc(OP_MAC_A,   1, HOLD_NONE, 7);
      4'd7:    w = uc(OP_MAC_A,   2, HOLD_NONE, 8);
      4'd8:    w = uc(OP_MAC_A,   3, HOLD_NONE, 9);
      4'd9:    w = uc(OP_MAC_A,   4, HOLD_NONE, 10);
      4'd10:   w = uc(OP_DRAIN,   0, HOLD_NONE, 11);
      4'd11:   w = uc(OP_ROUND_H, 0, HOLD_NONE, 12);
      4'd12:   w = uc(OP_ROUND_Y, 0, HOLD_NONE, 13);
      4'd13:   w = uc(OP_WRITE,   0, HOLD_OUT,  0);
      default: w = uc(OP_IDLE,    0, HOLD_NONE, 0);
    endcase
    return w;
  endfunction

endpackage

// ===== sv/iir_df1_if.sv =====
interface iir_df1_sample_if
  import iir_df1_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_W_DEFAULT
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface iir_df1_result_if
  import iir_df1_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_W_DEFAULT
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] filtered_sample;
  logic                           saturated;

  modport source (output valid, output filtered_sample, output saturated, input ready);
  modport sink (input valid, input filtered_sample, input saturated, output ready);
endinterface

interface iir_df1_cfg_if
  import iir_df1_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/iir_direct_form_one_filter.sv =====
// Fourth-order direct form I IIR filter in fixed point. Coefficients b0..b4 and a1..a4 are
// signed Q3.20 words loaded through the configuration channel (indexes 0..4, higher indexes
// ignored; write only while idle). Each sample transfer is taken only while the block is idle.
// After that transfer a 14-word microcode program (one idle word, then nine
// multiply-accumulates through a single 24 x (SAMPLE_WIDTH+8) multiplier, a drain, two
// rounding steps and a write-back) rounds half up, saturates and writes the output history.
// One sample is in flight at a time: the block takes no new sample until the write-back of
// the last one. A result waiting in the output register does not block the next sample
// transfer. saturated flags clipping of either the output or the stored history word.
module iir_direct_form_one_filter
  import iir_df1_pkg::*;
#(
  parameter int unsigned TAPS           = TAPS_DEFAULT,
  parameter int unsigned SAMPLE_WIDTH   = SAMPLE_W_DEFAULT,
  parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  iir_df1_cfg_if.sink      cfg_i,
  iir_df1_sample_if.sink   in_i,
  iir_df1_result_if.source out_o
);

  localparam int unsigned HIST_W  = SAMPLE_WIDTH + HIST_EXTRA;
  localparam int unsigned PROD_W  = COEF_W + HIST_W;
  localparam int unsigned POS_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned SLOT_CW = (POS_W + 1 > TAP_W) ? POS_W + 1 : TAP_W;
  localparam logic signed [ACC_W-1:0] HALF_H =
    {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] HALF_Y =
    {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS + HIST_EXTRA - 1);

  // sequencer
  step_t  step_q, step_d;
  ucode_t uw;
  logic   hold_active;
  logic   in_fire;
  logic   write_fire;

  // storage
  logic        [COEF_W-1:0] coef_q [NUM_COEFS];
  logic signed [SAMPLE_WIDTH-1:0] x_hist_q [TAPS];
  logic signed [HIST_W-1:0]       y_hist_q [TAPS];
  logic        [POS_W-1:0]        pos_q;

  // datapath
  logic        [SLOT_CW-1:0]    pe, je, te, slot_full;
  logic                         tap_ok;
  logic        [POS_W-1:0]      slot;
  logic        [COEF_IDX_W-1:0] coef_idx;
  logic signed [COEF_W-1:0]     coef_sel;
  logic signed [HIST_W-1:0]     oper;
  logic signed [PROD_W-1:0]     prod_d, prod_q;
  acc_op_e                      acc_op_d, acc_op_q;
  logic signed [ACC_W-1:0]      acc_q;
  logic signed [ACC_W-1:0]      rnd_h_q, rnd_y_q;
  logic                         h_fits, y_fits;
  logic signed [HIST_W-1:0]       hist_val;
  logic signed [SAMPLE_WIDTH-1:0] y_val;

  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_q;
  logic                           out_sat_q;

  assign uw          = ucode_rom(step_q);
  assign in_i.ready  = (uw.op == OP_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    unique case (uw.hold)
      HOLD_NONE: hold_active = 1'b0;
      HOLD_IN:   hold_active = !in_fire;
      HOLD_OUT:  hold_active = out_valid_q && !out_o.ready;
      default:   hold_active = 1'b0;
    endcase
    step_d = hold_active ? step_q : uw.next;
  end

  assign write_fire = (uw.op == OP_WRITE) && !hold_active;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // slot of x[n-j] / y[n-j]; taps past TAPS carry zero coefficients
  always_comb begin
    pe        = SLOT_CW'(pos_q);
    je        = SLOT_CW'(uw.tap);
    te        = SLOT_CW'(TAPS);
    tap_ok    = je < te;
    slot_full = (pe >= je) ? pe - je : pe + te - je;
    slot      = tap_ok ? slot_full[POS_W-1:0] : '0;
    coef_idx  = (uw.op == OP_MAC_A) ? COEF_IDX_W'(LAST_COEF_TAP) + COEF_IDX_W'(uw.tap)
                                    : COEF_IDX_W'(uw.tap);
    coef_sel  = tap_ok ? coef_q[coef_idx] : '0;
    oper      = (uw.op == OP_MAC_A) ? y_hist_q[slot]
                                    : {x_hist_q[slot], {HIST_EXTRA{1'b0}}};
    prod_d    = coef_sel * oper;
  end

  always_comb begin
    unique case (uw.op)
      OP_MAC_B: acc_op_d = ACC_ADD;
      OP_MAC_A: acc_op_d = ACC_SUB;
      default:  acc_op_d = ACC_NONE;
    endcase
  end

  always_comb begin
    h_fits   = rnd_h_q[ACC_W-1:HIST_W-1] == {(ACC_W-HIST_W+1){rnd_h_q[HIST_W-1]}};
    y_fits   = rnd_y_q[ACC_W-1:SAMPLE_WIDTH-1] ==
               {(ACC_W-SAMPLE_WIDTH+1){rnd_y_q[SAMPLE_WIDTH-1]}};
    hist_val = h_fits ? rnd_h_q[HIST_W-1:0]
                      : {rnd_h_q[ACC_W-1], {(HIST_W-1){~rnd_h_q[ACC_W-1]}}};
    y_val    = y_fits ? rnd_y_q[SAMPLE_WIDTH-1:0]
                      : {rnd_y_q[ACC_W-1], {(SAMPLE_WIDTH-1){~rnd_y_q[ACC_W-1]}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_COEFS; k++) begin
        coef_q[k] <= '0;
      end
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_B0_B1: begin
          coef_q[0] <= cfg_i.data[COEF_W-1:0];
          coef_q[1] <= cfg_i.data[CFG_DATA_W-1:COEF_W];
        end
        REG_B2_B3: begin
          coef_q[2] <= cfg_i.data[COEF_W-1:0];
          coef_q[3] <= cfg_i.data[CFG_DATA_W-1:COEF_W];
        end
        REG_B4_A1: begin
          coef_q[4] <= cfg_i.data[COEF_W-1:0];
          coef_q[5] <= cfg_i.data[CFG_DATA_W-1:COEF_W];
        end
        REG_A2_A3: begin
          coef_q[6] <= cfg_i.data[COEF_W-1:0];
          coef_q[7] <= cfg_i.data[CFG_DATA_W-1:COEF_W];
        end
        REG_A4: begin
          coef_q[8] <= cfg_i.data[COEF_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TAPS; k++) begin
        x_hist_q[k] <= '0;
        y_hist_q[k] <= '0;
      end
      pos_q <= '0;
    end else begin
      if (in_fire) begin
        x_hist_q[pos_q] <= in_i.sample;
      end
      if (write_fire) begin
        y_hist_q[pos_q] <= hist_val;
        pos_q           <= (pos_q == POS_W'(TAPS - 1)) ? '0 : pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_op_q    <= ACC_NONE;
      out_valid_q <= 1'b0;
    end else begin
      acc_op_q <= acc_op_d;
      if (write_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (in_fire) begin
      acc_q <= '0;
    end else begin
      unique case (acc_op_q)
        ACC_ADD: acc_q <= acc_q + ACC_W'(prod_q);
        ACC_SUB: acc_q <= acc_q - ACC_W'(prod_q);
        default: acc_q <= acc_q;
      endcase
    end
    if (uw.op == OP_ROUND_H) begin
      rnd_h_q <= (acc_q + HALF_H) >>> COEF_FRAC_BITS;
    end
    if (uw.op == OP_ROUND_Y) begin
      rnd_y_q <= (acc_q + HALF_Y) >>> (COEF_FRAC_BITS + HIST_EXTRA);
    end
    if (write_fire) begin
      out_sample_q <= y_val;
      out_sat_q    <= !(h_fits && y_fits);
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.filtered_sample = out_sample_q;
  assign out_o.saturated       = out_sat_q;

endmodule

// ===== sv/iir_df1_checker.sv =====
module iir_df1_checker
  import iir_df1_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_W_DEFAULT
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [SAMPLE_WIDTH-1:0] out_sample_i,
  input logic                    out_sat_i
);

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_stall |=> out_valid_i)
    else $error("result valid dropped before transfer");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_stall |=> ($stable(out_sample_i) && $stable(out_sat_i)))
    else $error("result payload changed while stalled");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("second sample taken while one is in progress");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(out_valid_i))
    else $error("result appeared straight after a sample transfer");

endmodule

bind iir_direct_form_one_filter iir_df1_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_iir_df1_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.filtered_sample),
  .out_sat_i    (out_o.saturated)
);
